// ===== rtl/treecode_mac_interaction_list_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multipole acceptance traversal
// Shared property forms used by the checker of the interaction list block.
// ----------------------------------------------------------------------------
`ifndef TREECODE_MAC_INTERACTION_LIST_ASSERT_SVH
`define TREECODE_MAC_INTERACTION_LIST_ASSERT_SVH

// same-cycle implication
`define TMIL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmil assertion failed");

// next-cycle implication
`define TMIL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmil assertion failed");

`endif

// ===== rtl/tmil_pkg.sv =====
// ----------------------------------------------------------------------------
// tmil_pkg
// Types, widths and codes of the multipole acceptance traversal block.
// ----------------------------------------------------------------------------
package tmil_pkg;

  localparam int MAX_NODES = 65536;
  localparam int MAX_LEVEL = 31;

  localparam int LVL_W      = 5;
  localparam int POS_W      = $clog2(MAX_NODES + 1);
  localparam int IDX_W      = 16;
  localparam int TOT_W      = 17;
  localparam int CRD_W      = 32;
  localparam int EXT_W      = 31;
  localparam int TSQ_W      = 17;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_W      = CRD_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DIST_W     = 2 * MUL_W;
  localparam int LHS_SHIFT  = 16;
  localparam int RHS_W      = DIST_W + TSQ_W;

  localparam logic [KIND_W-1:0] KIND_APPROX  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DIRECT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THETA_SQ = 3'd4;

  localparam logic [TSQ_W-1:0] THETA_SQ_RESET = 17'd32768;

  typedef struct packed {
    logic [LVL_W-1:0] node_level;
    logic [EXT_W-1:0] node_extent;
    logic [CRD_W-1:0] node_x;
    logic [CRD_W-1:0] node_y;
    logic [CRD_W-1:0] node_z;
    logic             last_node;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] entry_kind;
    logic [IDX_W-1:0]  entry_index;
    logic [TOT_W-1:0]  approx_total;
    logic [TOT_W-1:0]  direct_total;
    logic              overflow;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

endpackage

// ===== rtl/treecode_mac_interaction_list.sv =====
// ----------------------------------------------------------------------------
// treecode_mac_interaction_list
// Multipole acceptance traversal over a pre-order node stream.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  in_      | input     | in_valid/in_stall | in_item_t, one tree node
//  out_     | output    | out_valid/out_stall | out_item_t, list entry or summary
//  cfg_     | input     | cfg_we            | cfg_index, cfg_wdata
//
//  For each item the shared 33x33 multiplier forms the three squared distances, the two
//  halves of the theta product and the squared radius sum in turn; the results then
//  enter the output register one at a time while the output is not stalled.
//  Synchronous active-low reset: theta_sq to 0.5, control and config to zero.
//  in_stall stays high until every result of the item has entered the output
//  register; out_stall holds that register and the result drain.
// ----------------------------------------------------------------------------
module treecode_mac_interaction_list (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tmil_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tmil_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [tmil_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tmil_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_EMIT} state_t;

  localparam logic [2:0] PH_SQ_X  = 3'd0;
  localparam logic [2:0] PH_SQ_Y  = 3'd1;
  localparam logic [2:0] PH_SQ_Z  = 3'd2;
  localparam logic [2:0] PH_SUM   = 3'd3;
  localparam logic [2:0] PH_T_LO  = 3'd4;
  localparam logic [2:0] PH_T_HI  = 3'd5;
  localparam logic [2:0] PH_SQ_S  = 3'd6;
  localparam logic [2:0] PH_DEC   = 3'd7;

  localparam int LVL_W  = tmil_pkg::LVL_W;
  localparam int POS_W  = tmil_pkg::POS_W;
  localparam int CRD_W  = tmil_pkg::CRD_W;
  localparam int MUL_W  = tmil_pkg::MUL_W;
  localparam int DIST_W = tmil_pkg::DIST_W;
  localparam int RHS_W  = tmil_pkg::RHS_W;

  state_t                    state_r, state_nxt;
  logic [2:0]                phase_r, phase_nxt;

  logic [CRD_W-1:0]          cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [tmil_pkg::EXT_W-1:0] bext_r, bext_nxt;
  logic [tmil_pkg::TSQ_W-1:0] tsq_r, tsq_nxt;

  logic [LVL_W-1:0]          limit_r, limit_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic [POS_W-1:0]          acnt_r, acnt_nxt;
  logic [POS_W-1:0]          dcnt_r, dcnt_nxt;
  logic                      pend_vld_r, pend_vld_nxt;
  logic [POS_W-1:0]          pend_idx_r, pend_idx_nxt;
  logic [LVL_W-1:0]          pend_lvl_r, pend_lvl_nxt;
  logic                      ovf_r, ovf_nxt;

  logic [LVL_W-1:0]          lvl_r, lvl_nxt;
  logic                      last_r, last_nxt;
  logic                      ext_nz_r, ext_nz_nxt;
  logic [MUL_W-1:0]          dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt, s_r, s_nxt;
  logic [DIST_W-1:0]         dist_r, dist_nxt;
  logic [RHS_W-1:0]          rhs_r, rhs_nxt;

  tmil_pkg::out_item_t       res_r [3];
  tmil_pkg::out_item_t       res_nxt [3];
  logic [2:0]                res_vld_r, res_vld_nxt;
  logic                      out_valid_r, out_valid_nxt;
  tmil_pkg::out_item_t       out_item_r, out_item_nxt;

  tmil_pkg::mul_req_t        mul_req;
  logic [tmil_pkg::PROD_W-1:0] prod;

  tmil_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  function automatic logic [MUL_W-1:0] abs_diff(input logic [CRD_W-1:0] a,
                                                input logic [CRD_W-1:0] b);
    logic [CRD_W:0] d;
    d = {a[CRD_W-1], a} - {b[CRD_W-1], b};
    return MUL_W'(d[CRD_W] ? -d : d);
  endfunction

  function automatic tmil_pkg::out_item_t entry(input logic [tmil_pkg::KIND_W-1:0] kind,
                                                input logic [POS_W-1:0] idx);
    tmil_pkg::out_item_t e;
    e.entry_kind   = kind;
    e.entry_index  = tmil_pkg::IDX_W'(idx);
    e.approx_total = '0;
    e.direct_total = '0;
    e.overflow     = 1'b0;
    e.last_result  = 1'b0;
    return e;
  endfunction

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    logic [LVL_W-1:0] lvl_in;
    logic             hit;
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    cz_nxt       = cz_r;
    bext_nxt     = bext_r;
    tsq_nxt      = tsq_r;
    limit_nxt    = limit_r;
    pos_nxt      = pos_r;
    acnt_nxt     = acnt_r;
    dcnt_nxt     = dcnt_r;
    pend_vld_nxt = pend_vld_r;
    pend_idx_nxt = pend_idx_r;
    pend_lvl_nxt = pend_lvl_r;
    ovf_nxt      = ovf_r;
    lvl_nxt      = lvl_r;
    last_nxt     = last_r;
    ext_nz_nxt   = ext_nz_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    dz_nxt       = dz_r;
    s_nxt        = s_r;
    dist_nxt     = dist_r;
    rhs_nxt      = rhs_r;
    res_nxt[0]   = res_r[0];
    res_nxt[1]   = res_r[1];
    res_nxt[2]   = res_r[2];
    res_vld_nxt  = res_vld_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt = out_item_r;
    mul_req.a    = s_r;
    mul_req.b    = s_r;
    hit          = 1'b0;
    lvl_in       = (int'(in_item.node_level) > tmil_pkg::MAX_LEVEL) ?
                   LVL_W'(tmil_pkg::MAX_LEVEL) : in_item.node_level;

    if (cfg_we) begin
      case (cfg_index)
        tmil_pkg::REG_CENTER_X: cx_nxt = cfg_wdata[CRD_W-1:0];
        tmil_pkg::REG_CENTER_Y: cy_nxt = cfg_wdata[CRD_W-1:0];
        tmil_pkg::REG_CENTER_Z: cz_nxt = cfg_wdata[CRD_W-1:0];
        tmil_pkg::REG_EXTENT:   bext_nxt = cfg_wdata[tmil_pkg::EXT_W-1:0];
        tmil_pkg::REG_THETA_SQ: tsq_nxt = cfg_wdata[tmil_pkg::TSQ_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          lvl_nxt    = lvl_in;
          last_nxt   = in_item.last_node;
          ext_nz_nxt = (in_item.node_extent != '0);
          dx_nxt     = abs_diff(cx_r, in_item.node_x);
          dy_nxt     = abs_diff(cy_r, in_item.node_y);
          dz_nxt     = abs_diff(cz_r, in_item.node_z);
          s_nxt      = MUL_W'(in_item.node_extent) + MUL_W'(bext_r);
          dist_nxt   = '0;
          phase_nxt  = PH_SQ_X;
          state_nxt  = ST_CALC;
        end
      end
      ST_CALC: begin
        phase_nxt = phase_r + 3'd1;
        case (phase_r)
          PH_SQ_X: begin
            mul_req.a = dx_r;
            mul_req.b = dx_r;
          end
          PH_SQ_Y: begin
            mul_req.a = dy_r;
            mul_req.b = dy_r;
            dist_nxt  = dist_r + DIST_W'(prod);
          end
          PH_SQ_Z: begin
            mul_req.a = dz_r;
            mul_req.b = dz_r;
            dist_nxt  = dist_r + DIST_W'(prod);
          end
          PH_SUM: begin
            dist_nxt = dist_r + DIST_W'(prod);
          end
          PH_T_LO: begin
            mul_req.a = dist_r[MUL_W-1:0];
            mul_req.b = MUL_W'(tsq_r);
          end
          PH_T_HI: begin
            mul_req.a = dist_r[DIST_W-1:MUL_W];
            mul_req.b = MUL_W'(tsq_r);
            rhs_nxt   = RHS_W'(prod);
          end
          PH_SQ_S: begin
            rhs_nxt = rhs_r + (RHS_W'(prod) << MUL_W);
          end
          PH_DEC: begin
            hit         = ext_nz_r && ((RHS_W'(prod) << tmil_pkg::LHS_SHIFT) < rhs_r);
            res_vld_nxt = '0;
            if (32'(pos_r) >= tmil_pkg::MAX_NODES) begin
              ovf_nxt = 1'b1;
              if (last_r && pend_vld_r) begin
                res_nxt[0]     = entry(tmil_pkg::KIND_DIRECT, pend_idx_r);
                res_vld_nxt[0] = 1'b1;
                dcnt_nxt       = dcnt_nxt + 1'b1;
                pend_vld_nxt   = 1'b0;
              end
            end else begin
              if (pend_vld_r) begin
                if (lvl_r <= pend_lvl_r) begin
                  res_nxt[0]     = entry(tmil_pkg::KIND_DIRECT, pend_idx_r);
                  res_vld_nxt[0] = 1'b1;
                  dcnt_nxt       = dcnt_nxt + 1'b1;
                end else begin
                  limit_nxt = lvl_r;
                end
                pend_vld_nxt = 1'b0;
              end
              if (lvl_r <= limit_nxt) begin
                if (hit) begin
                  limit_nxt      = lvl_r;
                  res_nxt[1]     = entry(tmil_pkg::KIND_APPROX, pos_r);
                  res_vld_nxt[1] = 1'b1;
                  acnt_nxt       = acnt_nxt + 1'b1;
                end else if (last_r) begin
                  res_nxt[1]     = entry(tmil_pkg::KIND_DIRECT, pos_r);
                  res_vld_nxt[1] = 1'b1;
                  dcnt_nxt       = dcnt_nxt + 1'b1;
                end else begin
                  pend_vld_nxt = 1'b1;
                  pend_idx_nxt = pos_r;
                  pend_lvl_nxt = lvl_r;
                end
              end
              pos_nxt = pos_r + 1'b1;
            end
            if (last_r) begin
              res_nxt[2]              = entry(tmil_pkg::KIND_SUMMARY, '0);
              res_nxt[2].approx_total = tmil_pkg::TOT_W'(acnt_nxt);
              res_nxt[2].direct_total = tmil_pkg::TOT_W'(dcnt_nxt);
              res_nxt[2].overflow     = ovf_nxt;
              res_nxt[2].last_result  = 1'b1;
              res_vld_nxt[2]          = 1'b1;
              limit_nxt    = '0;
              pos_nxt      = '0;
              acnt_nxt     = '0;
              dcnt_nxt     = '0;
              pend_vld_nxt = 1'b0;
              pend_idx_nxt = '0;
              pend_lvl_nxt = '0;
              ovf_nxt      = 1'b0;
            end
            state_nxt = ST_EMIT;
          end
          default: ;
        endcase
      end
      ST_EMIT: begin
        if (res_vld_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (res_vld_r[0]) begin
            out_item_nxt   = res_r[0];
            res_vld_nxt[0] = 1'b0;
          end else if (res_vld_r[1]) begin
            out_item_nxt   = res_r[1];
            res_vld_nxt[1] = 1'b0;
          end else begin
            out_item_nxt   = res_r[2];
            res_vld_nxt[2] = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_SQ_X;
      cx_r        <= '0;
      cy_r        <= '0;
      cz_r        <= '0;
      bext_r      <= '0;
      tsq_r       <= tmil_pkg::THETA_SQ_RESET;
      limit_r     <= '0;
      pos_r       <= '0;
      acnt_r      <= '0;
      dcnt_r      <= '0;
      pend_vld_r  <= 1'b0;
      pend_idx_r  <= '0;
      pend_lvl_r  <= '0;
      ovf_r       <= 1'b0;
      res_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      cz_r        <= cz_nxt;
      bext_r      <= bext_nxt;
      tsq_r       <= tsq_nxt;
      limit_r     <= limit_nxt;
      pos_r       <= pos_nxt;
      acnt_r      <= acnt_nxt;
      dcnt_r      <= dcnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      pend_idx_r  <= pend_idx_nxt;
      pend_lvl_r  <= pend_lvl_nxt;
      ovf_r       <= ovf_nxt;
      res_vld_r   <= res_vld_nxt;
      out_valid_r <= out_valid_nxt;
      lvl_r       <= lvl_nxt;
      last_r      <= last_nxt;
      ext_nz_r    <= ext_nz_nxt;
      dx_r        <= dx_nxt;
      dy_r        <= dy_nxt;
      dz_r        <= dz_nxt;
      s_r         <= s_nxt;
      dist_r      <= dist_nxt;
      rhs_r       <= rhs_nxt;
      res_r[0]    <= res_nxt[0];
      res_r[1]    <= res_nxt[1];
      res_r[2]    <= res_nxt[2];
      out_item_r  <= out_item_nxt;
    end
  end

endmodule

// ===== rtl/tmil_mul.sv =====
// ----------------------------------------------------------------------------
// tmil_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module tmil_mul (
  input  logic                        clk,
  input  tmil_pkg::mul_req_t          req,
  output logic [tmil_pkg::PROD_W-1:0] prod
);

  logic [tmil_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= req.a * req.b;
  end

  assign prod = prod_r;

endmodule

// ===== rtl/tmil_checker.sv =====
// ----------------------------------------------------------------------------
// tmil_checker
// Port-level checks of the multipole acceptance traversal block.
// ----------------------------------------------------------------------------
`include "treecode_mac_interaction_list_assert.svh"

module tmil_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tmil_pkg::out_item_t out_item
);

  `TMIL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `TMIL_ASSERT_IMPL(a_last_is_summary, clk, rst_n, out_valid, (out_item.last_result == 1'b1) == (out_item.entry_kind == tmil_pkg::KIND_SUMMARY))
  `TMIL_ASSERT_IMPL(a_entry_totals_zero, clk, rst_n, out_valid && (out_item.entry_kind != tmil_pkg::KIND_SUMMARY), (out_item.approx_total == '0) && (out_item.direct_total == '0) && !out_item.overflow)
  `TMIL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))

endmodule

bind treecode_mac_interaction_list tmil_checker u_tmil_checker (.*);

// ===== dv/tb_treecode_mac_interaction_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_treecode_mac_interaction_list
// Drives pre-order node streams into the interaction list block under several
// batch settings, predicts every approximate entry, direct entry and pass
// summary, and checks the result stream in order with random idling on both
// channels and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_treecode_mac_interaction_list;

  localparam int LVL_W      = tmil_pkg::LVL_W;
  localparam int CRD_W      = tmil_pkg::CRD_W;
  localparam int EXT_W      = tmil_pkg::EXT_W;
  localparam int TSQ_W      = tmil_pkg::TSQ_W;
  localparam int IDX_W      = tmil_pkg::IDX_W;
  localparam int TOT_W      = tmil_pkg::TOT_W;
  localparam int KIND_W     = tmil_pkg::KIND_W;
  localparam int CFG_IDX_W  = tmil_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = tmil_pkg::CFG_DATA_W;

  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 24;

  localparam logic [CRD_W-1:0]     CRD_MAX = 32'h7FFF_FFFF;
  localparam logic [CRD_W-1:0]     CRD_MIN = 32'h8000_0000;
  localparam logic [EXT_W-1:0]     EXT_MAX = '1;
  localparam logic [TSQ_W-1:0]     TSQ_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP = '1;

  class interaction_list_tracker;
    logic signed [CRD_W-1:0] ctr_x, ctr_y, ctr_z;
    logic [EXT_W-1:0] batch_ext;
    logic [TSQ_W-1:0] theta_sq;
    logic [LVL_W-1:0] level_limit, held_level;
    int position, approx_n, direct_n, held_index;
    bit held_valid, overflow_seen;
    tmil_pkg::out_item_t due_entries[$];
    int errors;

    function new();
      ctr_x = '0;
      ctr_y = '0;
      ctr_z = '0;
      batch_ext = '0;
      theta_sq = tmil_pkg::THETA_SQ_RESET;
      errors = 0;
      clear_pass();
    endfunction

    function void clear_pass();
      level_limit = '0;
      position = 0;
      approx_n = 0;
      direct_n = 0;
      held_valid = 0;
      held_index = 0;
      held_level = '0;
      overflow_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        tmil_pkg::REG_CENTER_X: ctr_x = data;
        tmil_pkg::REG_CENTER_Y: ctr_y = data;
        tmil_pkg::REG_CENTER_Z: ctr_z = data;
        tmil_pkg::REG_EXTENT:   batch_ext = data[EXT_W-1:0];
        tmil_pkg::REG_THETA_SQ: theta_sq = data[TSQ_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CRD_W-1:0] gap_abs(logic signed [CRD_W-1:0] a,
                                       logic signed [CRD_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return (d < 0) ? CRD_W'(-d) : CRD_W'(d);
    endfunction

    function bit approximable(tmil_pkg::in_item_t n);
      logic [CRD_W-1:0] dx, dy, dz;
      logic [CRD_W:0] s;
      logic [127:0] lhs, rhs;
      if (n.node_extent == '0) return 0;
      dx = gap_abs(ctr_x, $signed(n.node_x));
      dy = gap_abs(ctr_y, $signed(n.node_y));
      dz = gap_abs(ctr_z, $signed(n.node_z));
      s = n.node_extent + batch_ext;
      lhs = (128'(s) * 128'(s)) << tmil_pkg::LHS_SHIFT;
      rhs = (128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz))
            * 128'(theta_sq);
      return lhs < rhs;
    endfunction

    function void list_entry(logic [KIND_W-1:0] kind, int idx, int a, int d,
                             bit ov, bit fin);
      tmil_pkg::out_item_t e;
      e.entry_kind   = kind;
      e.entry_index  = IDX_W'(idx);
      e.approx_total = TOT_W'(a);
      e.direct_total = TOT_W'(d);
      e.overflow     = ov;
      e.last_result  = fin;
      due_entries.push_back(e);
    endfunction

    function void traverse_node(tmil_pkg::in_item_t n);
      logic [LVL_W-1:0] lvl;
      int idx;
      lvl = n.node_level;
      if (lvl > tmil_pkg::MAX_LEVEL) lvl = LVL_W'(tmil_pkg::MAX_LEVEL);
      if (position >= tmil_pkg::MAX_NODES) begin
        overflow_seen = 1;
        if (n.last_node && held_valid) begin
          list_entry(tmil_pkg::KIND_DIRECT, held_index, 0, 0, 0, 0);
          direct_n++;
          held_valid = 0;
        end
      end else begin
        idx = position;
        if (held_valid) begin
          if (lvl <= held_level) begin
            list_entry(tmil_pkg::KIND_DIRECT, held_index, 0, 0, 0, 0);
            direct_n++;
          end else begin
            level_limit = lvl;
          end
          held_valid = 0;
        end
        if (lvl <= level_limit) begin
          if (approximable(n)) begin
            level_limit = lvl;
            list_entry(tmil_pkg::KIND_APPROX, idx, 0, 0, 0, 0);
            approx_n++;
          end else if (n.last_node) begin
            list_entry(tmil_pkg::KIND_DIRECT, idx, 0, 0, 0, 0);
            direct_n++;
          end else begin
            held_valid = 1;
            held_index = idx;
            held_level = lvl;
          end
        end
        position++;
      end
      if (n.last_node) begin
        list_entry(tmil_pkg::KIND_SUMMARY, 0, approx_n, direct_n, overflow_seen, 1);
        clear_pass();
      end
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void match_entry(tmil_pkg::out_item_t got);
      tmil_pkg::out_item_t e;
      if (due_entries.size() == 0) begin
        $error("unexpected item: entry_kind %0d entry_index %0d",
               got.entry_kind, got.entry_index);
        errors++;
        return;
      end
      e = due_entries.pop_front();
      compare_field("entry_kind", e.entry_kind, got.entry_kind);
      compare_field("entry_index", e.entry_index, got.entry_index);
      compare_field("approx_total", e.approx_total, got.approx_total);
      compare_field("direct_total", e.direct_total, got.direct_total);
      compare_field("overflow", e.overflow, got.overflow);
      compare_field("last_result", e.last_result, got.last_result);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  tmil_pkg::in_item_t    in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  tmil_pkg::out_item_t   out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  interaction_list_tracker tracker;
  bit tx_burst = 0;
  bit rx_burst = 0;
  bit rx_hold_req = 0;
  int pass_no = 0;
  int idle_cycles = 0;

  treecode_mac_interaction_list u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tmil_pkg::in_item_t node_rec(int lvl, logic [EXT_W-1:0] ext,
                                                  logic [CRD_W-1:0] x,
                                                  logic [CRD_W-1:0] y,
                                                  logic [CRD_W-1:0] z, bit fin);
    tmil_pkg::in_item_t n;
    n.node_level  = LVL_W'(lvl);
    n.node_extent = ext;
    n.node_x      = x;
    n.node_y      = y;
    n.node_z      = z;
    n.last_node   = fin;
    return n;
  endfunction

  function automatic logic [CRD_W-1:0] coord_near(logic [CRD_W-1:0] c);
    logic signed [CRD_W-1:0] off;
    if ($urandom_range(0, 9) == 0) return $urandom;
    off = $signed($urandom) >>> $urandom_range(0, 31);
    return c + off;
  endfunction

  function automatic tmil_pkg::in_item_t random_node(int lvl, bit fin);
    logic [EXT_W-1:0] ext;
    ext = ($urandom_range(0, 9) == 0) ? '0 : EXT_W'($urandom >> $urandom_range(1, 31));
    return node_rec(lvl, ext, coord_near(tracker.ctr_x), coord_near(tracker.ctr_y),
                    coord_near(tracker.ctr_z), fin);
  endfunction

  task automatic send_node(input tmil_pkg::in_item_t n);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= n;
    do @(posedge clk); while (in_stall);
    tracker.traverse_node(n);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.due_entries.size() != 0) @(negedge clk);
  endtask

  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic configure(input logic [CRD_W-1:0] x, input logic [CRD_W-1:0] y,
                           input logic [CRD_W-1:0] z, input logic [EXT_W-1:0] ext,
                           input logic [TSQ_W-1:0] tsq);
    write_reg(tmil_pkg::REG_CENTER_X, x);
    write_reg(tmil_pkg::REG_CENTER_Y, y);
    write_reg(tmil_pkg::REG_CENTER_Z, z);
    write_reg(tmil_pkg::REG_EXTENT, {1'($urandom), ext});
    write_reg(tmil_pkg::REG_THETA_SQ, {15'($urandom), tsq});
    write_reg(CFG_IDX_W'($urandom_range(tmil_pkg::REG_THETA_SQ + 1, REG_TOP)), $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic run_pass(input int len);
    int lvl;
    bit noisy, fin;
    noisy = ($urandom_range(0, 6) == 0);
    tx_burst = ($urandom_range(0, 3) == 0);
    pass_no++;
    lvl = 0;
    for (int i = 0; i < len; i++) begin
      if (pass_no % 4 == 1 && i > 0 && i == len / 2) drain_results();
      fin = (i == len - 1);
      if (noisy) begin
        lvl = $urandom_range(0, tmil_pkg::MAX_LEVEL);
        fin = fin || ($urandom_range(0, 9) == 0);
      end else if (i > 0) begin
        if ($urandom_range(0, 2) == 0) lvl = $urandom_range(0, lvl);
        else if (lvl < tmil_pkg::MAX_LEVEL) lvl++;
      end
      send_node(random_node(lvl, fin));
    end
  endtask

  task automatic run_phase(input int items);
    int n, len;
    n = 0;
    while (n < items) begin
      len = $urandom_range(1, 12);
      run_pass(len);
      n += len;
    end
  endtask

  initial begin
    tracker = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_node(node_rec(0, 1, CRD_MAX, 0, 0, 0));
    send_node(node_rec(1, EXT_MAX, 0, 0, 0, 0));
    send_node(node_rec(0, 0, CRD_MAX, 0, 0, 0));
    send_node(node_rec(1, EXT_MAX, 0, 0, 0, 0));
    send_node(node_rec(1, 1, CRD_MIN, CRD_MIN, CRD_MIN, 0));
    send_node(node_rec(31, 5, CRD_MAX, CRD_MAX, CRD_MAX, 0));
    send_node(node_rec(2, 7, CRD_MAX, 0, CRD_MIN, 0));
    send_node(node_rec(1, 'h100, 32'h0001_0000, 0, 0, 0));
    send_node(node_rec(0, 0, CRD_MAX, 0, 0, 1));
    send_node(node_rec(0, 1, CRD_MAX, 0, 0, 1));
    send_node(node_rec(0, 10, 0, 0, 0, 0));
    send_node(node_rec(0, 10, 0, 0, 0, 1));
    send_node(node_rec(0, 3, 1, 0, 0, 0));
    send_node(node_rec(4, 1, CRD_MAX, CRD_MIN, CRD_MAX, 1));
    send_node(node_rec(0, 1, CRD_MAX, 0, 0, 0));
    send_node(node_rec(3, 1, 0, 0, 0, 1));

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: configure(0, 0, 0, 0, TSQ_MAX);
        1: configure(CRD_MAX, CRD_MIN, CRD_MAX, EXT_MAX, TSQ_MAX);
        2: configure(CRD_MIN, CRD_MIN, CRD_MIN, 0, 0);
        3: configure($urandom, $urandom, $urandom,
                     EXT_W'($urandom >> $urandom_range(8, 24)), TSQ_W'($urandom));
        default: configure($urandom, $urandom, $urandom,
                           EXT_W'($urandom >> $urandom_range(1, 31)),
                           TSQ_W'($urandom_range(1, TSQ_MAX)));
      endcase
      if (ph == 1) rx_hold_req = 1;
      run_phase(PHASE_ITEMS);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (tracker.errors == 0 && tracker.due_entries.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    int hold, seen;
    seen = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (seen % 16 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      hold = rx_burst ? 0 : $urandom_range(0, 15);
      if (rx_hold_req) begin
        hold = LONG_HOLD;
        rx_hold_req = 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      tracker.match_entry(out_item);
      seen++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tmil_pkg.sv
rtl/tmil_mul.sv
rtl/treecode_mac_interaction_list.sv
rtl/tmil_checker.sv
dv/tb_treecode_mac_interaction_list.sv
